/* rtl/olsc_pkg.sv */
// Shared types and constants for the offset linear score classifier.
`timescale 1ns / 1ps

package olsc_pkg;

	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 16;
	localparam int DIFF_W   = SAMPLE_W + 1;
	localparam int PROD_W   = DIFF_W + COEF_W;
	localparam int ACC_W    = 40;
	localparam int IDX_W    = 5;
	localparam int POS_W    = 6;
	localparam int NW_W     = 6;
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 40;

	// tuser kind codes on the input side
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// Q8.8 minus one: stops accumulation for the rest of the row
	localparam logic signed [SAMPLE_W-1:0] MINUS_ONE_Q88 = -16'sd256;

	localparam logic [NW_W-1:0]  NUM_WEIGHTS_RST = 6'd20;
	localparam logic [POS_W-1:0] POS_MAX = '1;

	// one sample word leaving the control stage
	typedef struct packed {
		logic                       term;
		logic                       last;
		logic signed [SAMPLE_W-1:0] sample;
		logic signed [COEF_W-1:0]   middle;
		logic signed [COEF_W-1:0]   weight;
	} s1_word_t;

endpackage

/* rtl/olsc_ctrl.sv */
// Row control, coefficient memory and first pipeline register.
`timescale 1ns / 1ps

module olsc_ctrl import olsc_pkg::*; #(
	parameter int MAX_WEIGHTS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [NW_W-1:0]             cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        cmd,
	input  logic [IDX_W-1:0]            coef_index,
	input  logic signed [COEF_W-1:0]    middle,
	input  logic signed [COEF_W-1:0]    weight,
	input  logic signed [SAMPLE_W-1:0]  sample,
	input  logic                        last,
	output logic                        s1_valid,
	output s1_word_t                    s1_word,
	input  logic                        s1_take
);

	localparam int AW    = (MAX_WEIGHTS > 1) ? $clog2(MAX_WEIGHTS) : 1;
	localparam int LIM_W = NW_W + 1;
	localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_WEIGHTS);

	logic signed [COEF_W-1:0] mid_mem [MAX_WEIGHTS];
	logic signed [COEF_W-1:0] wt_mem  [MAX_WEIGHTS];

	logic [NW_W-1:0]  num_weights_q;
	logic [POS_W-1:0] row_pos_q;
	logic             first_seen_q;
	logic             leading_done_q;
	logic             halted_q;

	logic                       valid_s1;
	logic                       term_s1;
	logic                       last_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic signed [COEF_W-1:0]   middle_s1;
	logic signed [COEF_W-1:0]   weight_s1;

	logic             accept;
	logic             acc_sample;
	logic             acc_load;
	logic [LIM_W-1:0] limit;
	logic [LIM_W-1:0] slot_ext;
	logic [POS_W-1:0] slot6;
	logic             try_add;
	logic             in_range;
	logic             term_en;
	logic             halt_now;
	logic             lead_now;

	assign in_ready   = !valid_s1 || s1_take;
	assign accept     = in_valid && in_ready;
	assign acc_sample = accept && (cmd == CMD_SAMPLE);
	assign acc_load   = accept && (cmd == CMD_LOAD);

	assign limit    = ({1'b0, num_weights_q} < MAX_LIM) ? {1'b0, num_weights_q} : MAX_LIM;
	assign slot6    = POS_W'(coef_index);
	assign slot_ext = LIM_W'(coef_index);

	always_comb begin
		try_add  = 1'b0;
		lead_now = 1'b0;
		if (first_seen_q) begin
			if (!leading_done_q) begin
				if (sample != '0) begin
					lead_now = 1'b1;
					try_add  = 1'b1;
				end
			end else begin
				try_add = 1'b1;
			end
		end
		in_range = !halted_q && ({1'b0, row_pos_q} < limit);
		halt_now = try_add && in_range && (sample == MINUS_ONE_Q88);
		term_en  = try_add && in_range && (sample != MINUS_ONE_Q88);
	end

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_weights_q <= NUM_WEIGHTS_RST;
		end else if (cfg_we) begin
			num_weights_q <= cfg_wdata;
		end
	end

	// row state, cleared on the word that closes a row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pos_q      <= '0;
			first_seen_q   <= 1'b0;
			leading_done_q <= 1'b0;
			halted_q       <= 1'b0;
		end else if (acc_sample) begin
			if (last) begin
				row_pos_q      <= '0;
				first_seen_q   <= 1'b0;
				leading_done_q <= 1'b0;
				halted_q       <= 1'b0;
			end else begin
				first_seen_q <= 1'b1;
				if (lead_now) leading_done_q <= 1'b1;
				if (halt_now) halted_q <= 1'b1;
				if (term_en && (row_pos_q != POS_MAX)) row_pos_q <= row_pos_q + 1'b1;
			end
		end
	end

	// coefficient memory: write on load words, registered read on sample words
	always_ff @(posedge clk) begin
		if (acc_load && (slot_ext < MAX_LIM)) begin
			mid_mem[slot6[AW-1:0]] <= middle;
			wt_mem[slot6[AW-1:0]]  <= weight;
		end
		if (acc_sample) begin
			middle_s1 <= mid_mem[row_pos_q[AW-1:0]];
			weight_s1 <= wt_mem[row_pos_q[AW-1:0]];
			sample_s1 <= sample;
			term_s1   <= term_en;
			last_s1   <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc_sample) begin
			valid_s1 <= 1'b1;
		end else if (s1_take) begin
			valid_s1 <= 1'b0;
		end
	end

	assign s1_valid        = valid_s1;
	assign s1_word.term    = term_s1;
	assign s1_word.last    = last_s1;
	assign s1_word.sample  = sample_s1;
	assign s1_word.middle  = middle_s1;
	assign s1_word.weight  = weight_s1;

	a_lead_needs_first: assert property (@(posedge clk) disable iff (!arst_n)
		leading_done_q |-> first_seen_q)
		else $error("leading_done set without first sample");

	a_halt_needs_lead: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> leading_done_q)
		else $error("halted before leading zeros done");

	a_pos_needs_lead: assert property (@(posedge clk) disable iff (!arst_n)
		(row_pos_q != '0) |-> leading_done_q)
		else $error("terms counted before leading zeros done");

endmodule

/* rtl/olsc_mac.sv */
// Multiply stage, row accumulator and output register.
`timescale 1ns / 1ps

module olsc_mac import olsc_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s1_valid,
	input  s1_word_t                     s1_word,
	output logic                         s1_take,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [ACC_W-1:0]      score,
	output logic                         is_positive
);

	logic                     valid_s2;
	logic                     term_s2;
	logic                     last_s2;
	logic signed [PROD_W-1:0] prod_s2;

	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] score_q;
	logic                    out_valid_q;

	logic                    slot_free;
	logic                    s2_move;
	logic signed [DIFF_W-1:0] diff;
	logic signed [ACC_W-1:0] sum;

	assign slot_free = !out_valid_q || out_ready;
	// a non-last word only updates the accumulator and needs no output slot
	assign s2_move   = valid_s2 && (!last_s2 || slot_free);
	assign s1_take   = !valid_s2 || s2_move;

	assign diff = DIFF_W'(s1_word.sample) - DIFF_W'(s1_word.middle);

	always_ff @(posedge clk) begin
		if (s1_take && s1_valid) begin
			prod_s2 <= diff * s1_word.weight;
			term_s2 <= s1_word.term;
			last_s2 <= s1_word.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_take) begin
			valid_s2 <= s1_valid;
		end
	end

	assign sum = term_s2 ? (acc_q + ACC_W'(prod_s2)) : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (s2_move) begin
			acc_q <= last_s2 ? '0 : sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_move && last_s2) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move && last_s2) begin
			score_q <= sum;
		end
	end

	assign out_valid   = out_valid_q;
	assign score       = score_q;
	assign is_positive = !score_q[ACC_W-1] && (score_q != '0);

	a_acc_clear_after_row: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_move && last_s2) |=> (acc_q == '0))
		else $error("accumulator not cleared after row end");

endmodule

/* rtl/offset_linear_score_classifier.sv */
// Top level of the offset linear score classifier.
`timescale 1ns / 1ps

// Path: a row's closing word passes the coefficient read register, the product register
//   and the output register (coefficient read, multiply, accumulate), m_tvalid high until taken.
// Throughput: one word per cycle on s_* while not stalled, loads and samples alike; the MAC
//   stage stalls only when a row's closing word meets a score still waiting in the output register.
// Reset (arst_n low, async): row state, accumulator and valids clear,
//   num_weights returns to 20; coefficient memory is not cleared.

module offset_linear_score_classifier import olsc_pkg::*; #(
	parameter int MAX_WEIGHTS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// config: num_weights
	input  logic                    cfg_we,
	input  logic [NW_W-1:0]         cfg_wdata,
	// input stream
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// [4:0] coef_index, [20:5] middle, [36:21] weight, [52:37] sample, [55:53] zero
	input  logic [IN_TDATA_W-1:0]   s_tdata,
	input  logic                    s_tlast,   // last word of a row
	input  logic                    s_tuser,   // [0] cmd
	// result stream
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [OUT_TDATA_W-1:0]  m_tdata,   // [39:0] score
	output logic                    m_tuser    // [0] is_positive
);

	logic                 s1_valid;
	s1_word_t             s1_word;
	logic                 s1_take;
	logic signed [ACC_W-1:0] score;

	// Stage 0: row control decides whether a sample is a term, and the middle/weight
	// pair at the current row position is read from memory into the first pipeline register.
	olsc_ctrl #(
		.MAX_WEIGHTS (MAX_WEIGHTS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.cmd        (s_tuser),
		.coef_index (s_tdata[4:0]),
		.middle     (s_tdata[20:5]),
		.weight     (s_tdata[36:21]),
		.sample     (s_tdata[52:37]),
		.last       (s_tlast),
		.s1_valid   (s1_valid),
		.s1_word    (s1_word),
		.s1_take    (s1_take)
	);

	// Stages 1-2: (sample - middle) * weight is registered, then summed into
	// the row accumulator; the closing word moves the sum to the output.
	olsc_mac u_mac (
		.clk         (clk),
		.arst_n      (arst_n),
		.s1_valid    (s1_valid),
		.s1_word     (s1_word),
		.s1_take     (s1_take),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.score       (score),
		.is_positive (m_tuser)
	);

	assign m_tdata = OUT_TDATA_W'(score);

endmodule
